### design/mtdx_pkg.sv
// Package for the multitap delay crossfade block: opcodes, constants and the
// command record passed from the front end to the back end. No dependencies.
`timescale 1ns / 1ps
package mtdx_pkg;

    localparam logic [1:0] OP_SAMPLE  = 2'd0;
    localparam logic [1:0] OP_SET     = 2'd1;
    localparam logic [1:0] OP_DISABLE = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [1:0] CFG_FREEZE = 2'd0;
    localparam logic [1:0] CFG_LENGTH = 2'd1;
    localparam logic [1:0] CFG_DECAY  = 2'd2;
    localparam logic [1:0] CFG_GROW   = 2'd3;

    localparam logic [25:0] GAIN_ONE      = 26'd16777216;
    localparam logic [25:0] GAIN_START_IN = 26'd167772;
    localparam logic [25:0] GAIN_MAX      = 26'h3FFFFFF;
    localparam logic [15:0] FADE_LEN_RST  = 16'd4410;

    typedef struct packed {
        logic [1:0]  op;
        logic        valid_tap;
        logic signed [15:0] smp;
        logic [3:0]  sel;
        logic [15:0] dly;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  tap;
        logic signed [15:0] smp;
        logic [15:0] dn;
        logic        rep;
        logic        last;
    } res_t;

endpackage

### design/mtdx_front.sv
// Front end: accepts input items, saturates the delay, drops unused opcodes
// and queues command records. Depends on mtdx_pkg.
`timescale 1ns / 1ps
module mtdx_front #(
    parameter int RING_DEPTH = 65536,
    parameter int TAPS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         opcode,
    input  logic signed [15:0] sample_in,
    input  logic [3:0]         tap_sel,
    input  logic [15:0]        delay_req,
    output mtdx_pkg::cmd_t     cmd,
    output logic               cmd_valid,
    input  logic               cmd_take
);
    import mtdx_pkg::*;

    cmd_t q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    cmd_t       c;
    logic       acc, keep;

    assign full = (cnt_reg == 2'd2);
    assign acc = push && !full;
    assign keep = acc && (opcode != OP_UNUSED);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd = q_reg[rp_reg];

    always_comb
    begin
        c.op = opcode;
        c.valid_tap = (32'(tap_sel) < TAPS);
        c.smp = sample_in;
        c.sel = tap_sel;
        c.dly = (32'(delay_req) > RING_DEPTH - 2) ? 16'(RING_DEPTH - 2) : delay_req;
        cnt_next = cnt_reg + {1'b0, keep} - {1'b0, cmd_take && cmd_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (keep)
            begin
                wp_reg <= ~wp_reg;
            end
            if (cmd_take && cmd_valid)
            begin
                rp_reg <= ~rp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            q_reg[wp_reg] <= c;
        end
    end

endmodule

### design/mtdx_back.sv
// Back end: tap sequencer, ring memory, gain multiplier and result queue.
// Depends on mtdx_pkg.
`timescale 1ns / 1ps
module mtdx_back #(
    parameter int RING_DEPTH = 65536,
    parameter int TAPS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mtdx_pkg::cmd_t     cmd,
    input  logic               cmd_valid,
    output logic               cmd_take,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_idx,
    input  logic [25:0]        cfg_data,
    output logic               empty,
    input  logic               pop,
    output mtdx_pkg::res_t     res
);
    import mtdx_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int TW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam logic [AW-1:0] WRAP = AW'(RING_DEPTH - 1);
    localparam logic [16:0] LIM_POS = 17'd32767;
    localparam logic [16:0] LIM_NEG = 17'd32768;

    typedef enum logic [10:0] {
        S_CLR   = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_WRITE = 11'b00000000100,
        S_SCAN  = 11'b00000001000,
        S_RD0   = 11'b00000010000,
        S_RD1   = 11'b00000100000,
        S_GO    = 11'b00001000000,
        S_GI    = 11'b00010000000,
        S_MUL   = 11'b00100000000,
        S_EMIT  = 11'b01000000000,
        S_WAIT  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic        freeze_reg;
    logic [15:0] flen_reg;
    logic [25:0] fdec_reg, fgro_reg;

    logic signed [15:0] ring_mem [RING_DEPTH];
    logic signed [15:0] rd_reg, s0_reg, s1_reg;
    logic [AW-1:0] wptr_reg, clr_reg;

    logic [TAPS-1:0] act_reg, fad_reg;
    logic [15:0] cur_reg [TAPS];
    logic [15:0] tgt_reg [TAPS];
    logic [15:0] dst_reg [TAPS];
    logic [15:0] left_reg [TAPS];
    logic [25:0] go_reg [TAPS];
    logic [25:0] gi_reg [TAPS];
    logic [15:0] llen_reg [TAPS];
    logic [25:0] ldec_reg [TAPS];
    logic [25:0] lgro_reg [TAPS];

    logic [TW-1:0] t_reg;
    logic [51:0] prod_reg;
    logic [25:0] gmul;
    logic signed [42:0] p0, p1;
    logic signed [16:0] y0, y1;
    logic signed [17:0] ysum;
    logic signed [15:0] y;
    res_t        r;
    logic        rq_push, last_act;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] base;
    logic [15:0] rd_dly;
    logic        rd_en;
    logic [TAPS-1:0] above;

    // Result queue.
    res_t rq_reg [2];
    logic [1:0] rq_cnt_reg;
    logic rq_w_reg, rq_r_reg;
    logic rq_full;

    assign rq_full = (rq_cnt_reg == 2'd2);
    assign empty = (rq_cnt_reg == 2'd0);
    assign res = rq_reg[rq_r_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_cnt_reg <= 2'd0;
            rq_w_reg <= 1'b0;
            rq_r_reg <= 1'b0;
        end
        else
        begin
            rq_cnt_reg <= rq_cnt_reg + {1'b0, rq_push} - {1'b0, pop && !empty};
            if (rq_push)
            begin
                rq_w_reg <= ~rq_w_reg;
            end
            if (pop && !empty)
            begin
                rq_r_reg <= ~rq_r_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rq_push)
        begin
            rq_reg[rq_w_reg] <= r;
        end
    end

    // Saturating rounded gain product from the registered full product.
    always_comb
    begin
        logic [27:0] hi;
        hi = prod_reg[51:24] + {27'd0, prod_reg[23]};
        gmul = (hi > {2'b00, GAIN_MAX}) ? GAIN_MAX : hi[25:0];
    end

    // Magnitude of a product shifted down by 24 bits, clamped to lim.
    function automatic logic [16:0] sat_shift(input logic [42:0] v, input logic [16:0] lim);
        logic [42:0] m;
        m = v >> 24;
        return (m > 43'(lim)) ? lim : m[16:0];
    endfunction

    always_comb
    begin
        p0 = 43'(s0_reg) * $signed({17'd0, go_reg[t_reg]});
        p1 = 43'(s1_reg) * $signed({17'd0, gi_reg[t_reg]});
        y0 = (p0 < 0) ? -$signed(sat_shift(-p0, LIM_NEG)) : $signed(sat_shift(p0, LIM_POS));
        y1 = (p1 < 0) ? -$signed(sat_shift(-p1, LIM_NEG)) : $signed(sat_shift(p1, LIM_POS));
        ysum = 18'(y0) + 18'(y1);
        if (ysum > 18'sd32767)
        begin
            y = 16'sd32767;
        end
        else if (ysum < -18'sd32768)
        begin
            y = -16'sd32768;
        end
        else
        begin
            y = ysum[15:0];
        end
    end

    // Tap t is the last active one if no higher tap is active.
    always_comb
    begin
        for (int i = 0; i < TAPS; i++)
        begin
            above[i] = 1'b0;
            for (int j = i + 1; j < TAPS; j++)
            begin
                above[i] = above[i] | act_reg[j];
            end
        end
        last_act = !above[t_reg];
    end

    always_comb
    begin
        rd_dly = (state_reg == S_RD0) ? cur_reg[t_reg] : dst_reg[t_reg];
        base = (wptr_reg >= AW'(rd_dly)) ? wptr_reg : wptr_reg + WRAP;
        rd_addr = base - AW'(rd_dly);
        rd_en = (state_reg == S_RD0) || (state_reg == S_RD1);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLR)
        begin
            ring_mem[clr_reg] <= 16'sd0;
        end
        else if (state_reg == S_WRITE && !freeze_reg)
        begin
            ring_mem[wptr_reg] <= cmd.smp;
        end
        if (rd_en)
        begin
            rd_reg <= ring_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_take = 1'b0;
        rq_push = 1'b0;
        r = '0;
        r.tap = 4'(t_reg);
        unique case (state_reg)
            S_CLR:
            begin
                if (clr_reg == AW'(RING_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid && !rq_full)
                begin
                    if (cmd.op == OP_SAMPLE)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        cmd_take = 1'b1;
                        rq_push = 1'b1;
                        r.tap = cmd.sel;
                        r.rep = 1'b1;
                        r.last = 1'b1;
                        if (cmd.op == OP_SET && cmd.valid_tap)
                        begin
                            if (!act_reg[cmd.sel[TW-1:0]])
                            begin
                                r.dn = cmd.dly;
                            end
                            else if (!fad_reg[cmd.sel[TW-1:0]] && flen_reg == 16'd0)
                            begin
                                r.dn = cmd.dly;
                            end
                            else
                            begin
                                r.dn = cur_reg[cmd.sel[TW-1:0]];
                            end
                        end
                    end
                end
            end
            S_WRITE: state_next = S_SCAN;
            S_SCAN:
            begin
                if (!act_reg[t_reg])
                begin
                    if (32'(t_reg) == TAPS - 1)
                    begin
                        state_next = S_IDLE;
                        cmd_take = 1'b1;
                    end
                end
                else
                begin
                    state_next = S_RD0;
                end
            end
            S_RD0: state_next = S_RD1;
            S_RD1: state_next = fad_reg[t_reg] ? S_GO : S_WAIT;
            S_WAIT: state_next = S_EMIT;
            S_GO: state_next = S_GI;
            S_GI: state_next = S_MUL;
            S_MUL: state_next = S_EMIT;
            S_EMIT:
            begin
                if (!rq_full)
                begin
                    rq_push = 1'b1;
                    r.smp = fad_reg[t_reg] ? y : s0_reg;
                    r.last = last_act;
                    if (32'(t_reg) == TAPS - 1)
                    begin
                        state_next = S_IDLE;
                        cmd_take = 1'b1;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg <= '0;
            freeze_reg <= 1'b0;
            flen_reg <= FADE_LEN_RST;
            fdec_reg <= GAIN_ONE;
            fgro_reg <= GAIN_ONE;
            wptr_reg <= '0;
            t_reg <= '0;
            s0_reg <= '0;
            s1_reg <= '0;
            prod_reg <= '0;
            act_reg <= '0;
            fad_reg <= '0;
            for (int i = 0; i < TAPS; i++)
            begin
                cur_reg[i] <= '0;
                tgt_reg[i] <= '0;
                dst_reg[i] <= '0;
                left_reg[i] <= '0;
                go_reg[i] <= GAIN_ONE;
                gi_reg[i] <= GAIN_START_IN;
                llen_reg[i] <= '0;
                ldec_reg[i] <= GAIN_ONE;
                lgro_reg[i] <= GAIN_ONE;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    CFG_FREEZE: freeze_reg <= cfg_data[0];
                    CFG_LENGTH: flen_reg <= cfg_data[15:0];
                    CFG_DECAY:  fdec_reg <= cfg_data;
                    CFG_GROW:   fgro_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    t_reg <= '0;
                    if (cmd_valid && !rq_full && cmd.valid_tap)
                    begin
                        if (cmd.op == OP_SET)
                        begin
                            if (!act_reg[cmd.sel[TW-1:0]])
                            begin
                                cur_reg[cmd.sel[TW-1:0]] <= cmd.dly;
                                tgt_reg[cmd.sel[TW-1:0]] <= cmd.dly;
                                dst_reg[cmd.sel[TW-1:0]] <= cmd.dly;
                                left_reg[cmd.sel[TW-1:0]] <= '0;
                                fad_reg[cmd.sel[TW-1:0]] <= 1'b0;
                                act_reg[cmd.sel[TW-1:0]] <= 1'b1;
                            end
                            else if (!fad_reg[cmd.sel[TW-1:0]])
                            begin
                                tgt_reg[cmd.sel[TW-1:0]] <= cmd.dly;
                                dst_reg[cmd.sel[TW-1:0]] <= cmd.dly;
                                if (flen_reg == 16'd0)
                                begin
                                    cur_reg[cmd.sel[TW-1:0]] <= cmd.dly;
                                end
                                else
                                begin
                                    llen_reg[cmd.sel[TW-1:0]] <= flen_reg;
                                    ldec_reg[cmd.sel[TW-1:0]] <= fdec_reg;
                                    lgro_reg[cmd.sel[TW-1:0]] <= fgro_reg;
                                    left_reg[cmd.sel[TW-1:0]] <= flen_reg;
                                    go_reg[cmd.sel[TW-1:0]] <= GAIN_ONE;
                                    gi_reg[cmd.sel[TW-1:0]] <= GAIN_START_IN;
                                    fad_reg[cmd.sel[TW-1:0]] <= 1'b1;
                                end
                            end
                            else
                            begin
                                tgt_reg[cmd.sel[TW-1:0]] <= cmd.dly;
                            end
                        end
                        else if (cmd.op == OP_DISABLE)
                        begin
                            act_reg[cmd.sel[TW-1:0]] <= 1'b0;
                            fad_reg[cmd.sel[TW-1:0]] <= 1'b0;
                            left_reg[cmd.sel[TW-1:0]] <= '0;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (!act_reg[t_reg])
                    begin
                        if (32'(t_reg) == TAPS - 1)
                        begin
                            wptr_reg <= (wptr_reg == WRAP - AW'(1)) ? '0 : wptr_reg + AW'(1);
                        end
                        else
                        begin
                            t_reg <= t_reg + TW'(1);
                        end
                    end
                end
                S_RD1:
                begin
                    s0_reg <= rd_reg;
                    prod_reg <= 52'(go_reg[t_reg]) * 52'(ldec_reg[t_reg]);
                end
                S_WAIT:
                begin
                    s0_reg <= rd_reg;
                end
                S_GO:
                begin
                    s1_reg <= rd_reg;
                    go_reg[t_reg] <= gmul;
                    prod_reg <= 52'(gi_reg[t_reg]) * 52'(lgro_reg[t_reg]);
                end
                S_GI:
                begin
                    gi_reg[t_reg] <= gmul;
                end
                S_EMIT:
                begin
                    if (!rq_full)
                    begin
                        if (fad_reg[t_reg])
                        begin
                            if (left_reg[t_reg] == 16'd1)
                            begin
                                cur_reg[t_reg] <= dst_reg[t_reg];
                                if (tgt_reg[t_reg] != dst_reg[t_reg]
                                    && llen_reg[t_reg] != 16'd0)
                                begin
                                    dst_reg[t_reg] <= tgt_reg[t_reg];
                                    left_reg[t_reg] <= llen_reg[t_reg];
                                    go_reg[t_reg] <= GAIN_ONE;
                                    gi_reg[t_reg] <= GAIN_START_IN;
                                end
                                else
                                begin
                                    left_reg[t_reg] <= 16'd0;
                                    fad_reg[t_reg] <= 1'b0;
                                end
                            end
                            else
                            begin
                                left_reg[t_reg] <= left_reg[t_reg] - 16'd1;
                            end
                        end
                        if (32'(t_reg) == TAPS - 1)
                        begin
                            wptr_reg <= (wptr_reg == WRAP - AW'(1)) ? '0 : wptr_reg + AW'(1);
                        end
                        else
                        begin
                            t_reg <= t_reg + TW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

### design/multitap_delay_crossfade_top.sv
// Reply: a command item gives its reply once it is taken by the idle back
// end with room in the result queue. Audio: an item is written to the ring
// unless frozen, then every tap is scanned; each active tap gives a result
// as it finishes. The back end takes no new item before the last tap is done,
// as the single tap sequencer, ring read port and gain multiplier serve all taps.
// Reset: asynchronous; afterwards a clearing pass zeroes every ring entry
// before the first item is processed.
`timescale 1ns / 1ps
module multitap_delay_crossfade_top #(
    parameter int RING_DEPTH = 65536,
    parameter int TAPS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         opcode,
    input  logic signed [15:0] sample_in,
    input  logic [3:0]         tap_sel,
    input  logic [15:0]        delay_req,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_idx,
    input  logic [25:0]        cfg_data,
    output logic               empty,
    input  logic               pop,
    output logic [3:0]         tap_out,
    output logic signed [15:0] sample_out,
    output logic [15:0]        delay_now,
    output logic               is_reply,
    output logic               last
);
    import mtdx_pkg::*;

    cmd_t cmd;
    res_t res;
    logic cmd_valid, cmd_take;

    mtdx_front #(.RING_DEPTH(RING_DEPTH), .TAPS(TAPS)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .opcode(opcode),
        .sample_in(sample_in), .tap_sel(tap_sel), .delay_req(delay_req),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
    );

    mtdx_back #(.RING_DEPTH(RING_DEPTH), .TAPS(TAPS)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .cmd_valid(cmd_valid),
        .cmd_take(cmd_take), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_data(cfg_data), .empty(empty), .pop(pop), .res(res)
    );

    assign tap_out = res.tap;
    assign sample_out = res.smp;
    assign delay_now = res.dn;
    assign is_reply = res.rep;
    assign last = res.last;

endmodule

### design/mtdx_checker.sv
// Port-level checker for the multitap delay crossfade block, bound to the top.
// Depends on nothing but the top level's ports.
`timescale 1ns / 1ps
module mtdx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [3:0]  tap_out,
    input logic [15:0] delay_now,
    input logic        is_reply,
    input logic        last
);
    a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && is_reply) |-> last)
        else $error("A reply item must be marked last.");

    a_audio_no_delay: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !is_reply) |-> (delay_now == 16'd0))
        else $error("An audio item must carry a zero delay.");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(tap_out)))
        else $error("A waiting item must hold.");

endmodule

bind multitap_delay_crossfade_top mtdx_checker u_chk (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .tap_out(tap_out),
    .delay_now(delay_now), .is_reply(is_reply), .last(last)
);
